FILE: rtl/stepper_trapezoid_ramp_top_macros.svh
// Assertion macros for the stepper ramp checker.
// Depends on nothing; included by the checker file.
`ifndef STEPPER_TRAPEZOID_RAMP_TOP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define STR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: rtl/str_pkg.sv
// Shared types and constants of the stepper ramp generator.
// Depends on nothing; used by every module of the block.
package str_pkg;

   typedef enum logic [1:0] {
      PH_STOP  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_RUN   = 2'd2,
      PH_DECEL = 2'd3
   } phase_type;

   localparam logic FUNC_MOVE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR  = 3'd5;

   localparam logic [15:0]        ONE_STEP_DELAY = 16'd1000;
   localparam logic signed [17:0] DECEL_FLOOR    = -18'sd65536;

   localparam int DIV_W   = 48;
   localparam int DIVR_W  = 20;
   localparam int CNT_W   = 6;
   localparam int TICK_NW = 21;

   typedef struct packed {
      logic              func;
      logic signed [15:0] move_steps;
   } req_type;

   typedef struct packed {
      logic [15:0]        step_delay_out;
      logic signed [31:0] position_out;
      logic [1:0]         phase_out;
      logic               dir_out;
      logic               running_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MV_MUL1,
      ST_MV_DIV1,
      ST_MV_WAIT1,
      ST_MV_MUL2,
      ST_MV_DIV2,
      ST_MV_WAIT2,
      ST_MV_PLAN,
      ST_TK_WAIT,
      ST_TK_FIN
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MOVE,
      OP_MUL1,
      OP_DIV1,
      OP_ALIM,
      OP_MUL2,
      OP_DIV2,
      OP_PLAN,
      OP_TICK,
      OP_TK_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic move_short;
      logic tick_div;
      logic le_limit;
      logic decel_zero;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/str_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on str_pkg; used by the ramp datapath.
module str_div
   import str_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   input  logic [CNT_W-1:0]  iters,
   output logic              done,
   output logic [DIV_W-1:0]  quot,
   output logic [DIVR_W-1:0] rem
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  q_ff, q_in;
   logic [DIVR_W-1:0] r_ff, r_in;
   logic [DIVR_W-1:0] d_ff, d_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              ge;

   assign trial = {r_ff, q_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_W-2:0], ge};
         r_in   = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

FILE: rtl/str_datapath.sv
// Ramp datapath: registers, move planning arithmetic, tick recurrence, result register.
// Depends on str_pkg and str_div; driven by the ramp controller.
module str_datapath
   import str_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  req_type               req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   logic [15:0] accel_rate_ff, decel_rate_ff, min_delay_ff, first_delay_ff;
   logic [30:0] speed_limit_ff;
   logic        invert_ff;

   phase_type          phase_ff, phase_in;
   logic [15:0]        cur_delay_ff, cur_delay_in;
   logic signed [19:0] rem_ff, rem_in;
   logic [16:0]        steps_done_ff, steps_done_in;
   logic signed [17:0] ramp_ff, ramp_in;
   logic signed [17:0] decel_begin_ff, decel_begin_in;
   logic signed [17:0] decel_len_ff, decel_len_in;
   logic [15:0]        aed_ff, aed_in;
   logic [31:0]        pos_ff, pos_in;
   logic               dir_ff, dir_in;
   logic               moving_ff, moving_in;

   logic [16:0]        steps_ff, steps_in;
   logic [16:0]        alim_ff, alim_in;
   logic               le_ff, le_in;
   logic [DIV_W-1:0]   prod_ff, prod_in;
   logic [15:0]        issued_ff, issued_in;
   logic               num_neg_ff, num_neg_in;
   logic               den_neg_ff, den_neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [CNT_W-1:0]  div_iters;
   logic              div_done;
   logic [DIV_W-1:0]  div_quot;
   logic [DIVR_W-1:0] div_rem;

   logic [15:0]        raw_steps;
   logic               req_neg;
   logic [16:0]        req_steps;
   logic [16:0]        rate_sum;
   logic [32:0]        mul1;
   logic [46:0]        mul2;
   logic [16:0]        alim_c;
   logic signed [17:0] ramp_inc;
   logic signed [19:0] den_c;
   logic [19:0]        den_abs;
   logic signed [20:0] num_c;
   logic [20:0]        num_abs;
   logic signed [21:0] q_s;
   logic signed [19:0] r_s;
   logic signed [22:0] delay_diff;
   logic [15:0]        next_delay;
   logic signed [17:0] dl_c;
   logic               reach_decel;

   str_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign raw_steps = req_data.move_steps;
   assign req_neg   = raw_steps[15];
   assign req_steps = req_neg ? (17'd65536 - {1'b0, raw_steps}) : {1'b0, raw_steps};
   assign rate_sum  = {1'b0, accel_rate_ff} + {1'b0, decel_rate_ff};
   assign mul1      = steps_ff * decel_rate_ff;
   assign mul2      = speed_limit_ff * accel_rate_ff;

   always_comb begin
      alim_c = (rate_sum == 17'd0) ? 17'd0 : div_quot[16:0];
      if (alim_c == 17'd0) begin
         alim_c = 17'd1;
      end
   end

   assign ramp_inc = ramp_ff + 18'sd1;
   assign den_c    = {ramp_inc, 2'b01};
   assign den_abs  = den_c[19] ? 20'(-den_c) : den_c;
   assign num_c    = {4'b0, cur_delay_ff, 1'b0} + {rem_ff[19], rem_ff};
   assign num_abs  = num_c[20] ? 21'(-num_c) : num_c;

   assign q_s = (num_neg_ff ^ den_neg_ff) ? -$signed({1'b0, div_quot[TICK_NW-1:0]})
                                           : $signed({1'b0, div_quot[TICK_NW-1:0]});
   assign r_s = num_neg_ff ? -$signed(div_rem) : $signed(div_rem);
   assign delay_diff = $signed({7'b0, cur_delay_ff}) - {q_s[21], q_s};

   always_comb begin
      if (delay_diff[22]) begin
         next_delay = 16'd0;
      end else if (|delay_diff[21:16]) begin
         next_delay = 16'hFFFF;
      end else begin
         next_delay = delay_diff[15:0];
      end
   end

   always_comb begin
      if (le_ff) begin
         dl_c = $signed({1'b0, alim_ff}) - $signed({1'b0, steps_ff});
      end else if (decel_rate_ff == 16'd0) begin
         dl_c = DECEL_FLOOR;
      end else if (div_quot > DIV_W'(65536)) begin
         dl_c = DECEL_FLOOR;
      end else begin
         dl_c = -$signed({1'b0, div_quot[16:0]});
      end
      if (dl_c == 18'sd0) begin
         dl_c = -18'sd1;
      end
   end

   assign reach_decel = $signed({1'b0, steps_done_ff}) >= decel_begin_ff;

   always_comb begin
      phase_in       = phase_ff;
      cur_delay_in   = cur_delay_ff;
      rem_in         = rem_ff;
      steps_done_in  = steps_done_ff;
      ramp_in        = ramp_ff;
      decel_begin_in = decel_begin_ff;
      decel_len_in   = decel_len_ff;
      aed_in         = aed_ff;
      pos_in         = pos_ff;
      dir_in         = dir_ff;
      moving_in      = moving_ff;
      steps_in       = steps_ff;
      alim_in        = alim_ff;
      le_in          = le_ff;
      prod_in        = prod_ff;
      issued_in      = issued_ff;
      num_neg_in     = num_neg_ff;
      den_neg_in     = den_neg_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      div_start      = 1'b0;
      div_dividend   = prod_ff;
      div_divisor    = {3'b0, rate_sum};
      div_iters      = CNT_W'(DIV_W);
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_MOVE: begin
            dir_in   = req_neg ^ invert_ff;
            steps_in = req_steps;
            if (req_steps == 17'd1) begin
               ramp_in      = -18'sd1;
               phase_in     = PH_DECEL;
               cur_delay_in = ONE_STEP_DELAY;
               moving_in    = 1'b1;
            end
         end
         OP_MUL1: begin
            prod_in = DIV_W'(mul1);
         end
         OP_DIV1: begin
            div_start = 1'b1;
         end
         OP_ALIM: begin
            alim_in = alim_c;
            le_in   = {14'b0, alim_c} <= speed_limit_ff;
         end
         OP_MUL2: begin
            prod_in = DIV_W'(mul2);
         end
         OP_DIV2: begin
            div_start   = 1'b1;
            div_divisor = {4'b0, decel_rate_ff};
         end
         OP_PLAN: begin
            decel_len_in   = dl_c;
            decel_begin_in = $signed({1'b0, steps_ff}) + dl_c;
            if (first_delay_ff <= min_delay_ff) begin
               cur_delay_in = min_delay_ff;
               phase_in     = PH_RUN;
            end else begin
               cur_delay_in = first_delay_ff;
               phase_in     = PH_ACCEL;
            end
            steps_done_in = '0;
            rem_in        = '0;
            ramp_in       = '0;
            moving_in     = 1'b1;
         end
         OP_TICK: begin
            issued_in = cur_delay_ff;
            if (moving_ff) begin
               pos_in = dir_ff ? (pos_ff - 32'd1) : (pos_ff + 32'd1);
            end
            unique case (phase_ff)
               PH_STOP: begin
                  steps_done_in = '0;
                  rem_in        = '0;
                  moving_in     = 1'b0;
               end
               PH_RUN: begin
                  steps_done_in = steps_done_ff + 17'd1;
               end
               PH_ACCEL, PH_DECEL: begin
                  steps_done_in = steps_done_ff + 17'd1;
                  ramp_in       = ramp_inc;
                  num_neg_in    = num_c[20];
                  den_neg_in    = den_c[19];
                  div_start     = 1'b1;
                  div_dividend  = {num_abs, (DIV_W-TICK_NW)'(0)};
                  div_divisor   = den_abs;
                  div_iters     = CNT_W'(TICK_NW);
               end
            endcase
         end
         OP_TK_FIN: begin
            unique case (phase_ff)
               PH_STOP: begin
                  cur_delay_in = 16'd0;
               end
               PH_ACCEL: begin
                  rem_in       = r_s;
                  cur_delay_in = next_delay;
                  if (reach_decel) begin
                     ramp_in  = decel_len_ff;
                     phase_in = PH_DECEL;
                  end else if (next_delay <= min_delay_ff) begin
                     aed_in       = next_delay;
                     cur_delay_in = min_delay_ff;
                     rem_in       = '0;
                     phase_in     = PH_RUN;
                  end
               end
               PH_RUN: begin
                  cur_delay_in = min_delay_ff;
                  if (reach_decel) begin
                     ramp_in      = decel_len_ff;
                     cur_delay_in = aed_ff;
                     phase_in     = PH_DECEL;
                  end
               end
               PH_DECEL: begin
                  rem_in       = r_s;
                  cur_delay_in = next_delay;
                  if (!ramp_ff[17]) begin
                     phase_in = PH_STOP;
                  end
               end
            endcase
            rsp_in.step_delay_out = issued_ff;
            rsp_in.position_out   = pos_ff;
            rsp_in.phase_out      = phase_in;
            rsp_in.dir_out        = dir_ff;
            rsp_in.running_out    = moving_ff;
            rsp_valid_in          = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_rate_ff  <= 16'd100;
         decel_rate_ff  <= 16'd100;
         min_delay_ff   <= 16'd100;
         speed_limit_ff <= 31'd1;
         first_delay_ff <= 16'd1000;
         invert_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCEL_RATE:  accel_rate_ff  <= csr_wr_data[15:0];
            CSR_DECEL_RATE:  decel_rate_ff  <= csr_wr_data[15:0];
            CSR_MIN_DELAY:   min_delay_ff   <= csr_wr_data[15:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_wr_data[30:0];
            CSR_FIRST_DELAY: first_delay_ff <= csr_wr_data[15:0];
            CSR_INVERT_DIR:  invert_ff      <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STOP;
         cur_delay_ff   <= '0;
         rem_ff         <= '0;
         steps_done_ff  <= '0;
         ramp_ff        <= '0;
         decel_begin_ff <= '0;
         decel_len_ff   <= '0;
         aed_ff         <= '0;
         pos_ff         <= '0;
         dir_ff         <= 1'b0;
         moving_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         cur_delay_ff   <= cur_delay_in;
         rem_ff         <= rem_in;
         steps_done_ff  <= steps_done_in;
         ramp_ff        <= ramp_in;
         decel_begin_ff <= decel_begin_in;
         decel_len_ff   <= decel_len_in;
         aed_ff         <= aed_in;
         pos_ff         <= pos_in;
         dir_ff         <= dir_in;
         moving_ff      <= moving_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      steps_ff   <= steps_in;
      alim_ff    <= alim_in;
      le_ff      <= le_in;
      prod_ff    <= prod_in;
      issued_ff  <= issued_in;
      num_neg_ff <= num_neg_in;
      den_neg_ff <= den_neg_in;
      rsp_ff     <= rsp_in;
   end

   assign status.move_short = req_steps <= 17'd1;
   assign status.tick_div   = (phase_ff == PH_ACCEL) || (phase_ff == PH_DECEL);
   assign status.le_limit   = {14'b0, alim_c} <= speed_limit_ff;
   assign status.decel_zero = decel_rate_ff == 16'd0;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/str_ctrl.sv
// Ramp controller: sequences move planning and tick updates in the datapath.
// Depends on str_pkg; talks to the datapath through command and status structs.
module str_ctrl
   import str_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_func,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_TICK) begin
                  state_in = status.tick_div ? ST_TK_WAIT : ST_TK_FIN;
               end else begin
                  state_in = status.move_short ? ST_IDLE : ST_MV_MUL1;
               end
            end
         end
         ST_MV_MUL1:  state_in = ST_MV_DIV1;
         ST_MV_DIV1:  state_in = ST_MV_WAIT1;
         ST_MV_WAIT1: begin
            if (status.div_done) begin
               state_in = (status.le_limit || status.decel_zero) ? ST_MV_PLAN : ST_MV_MUL2;
            end
         end
         ST_MV_MUL2:  state_in = ST_MV_DIV2;
         ST_MV_DIV2:  state_in = ST_MV_WAIT2;
         ST_MV_WAIT2: begin
            if (status.div_done) begin
               state_in = ST_MV_PLAN;
            end
         end
         ST_MV_PLAN:  state_in = ST_IDLE;
         ST_TK_WAIT: begin
            if (status.div_done) begin
               state_in = ST_TK_FIN;
            end
         end
         ST_TK_FIN: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = (req_func == FUNC_TICK) ? OP_TICK : OP_MOVE;
            end
         end
         ST_MV_MUL1:  cmd.op = OP_MUL1;
         ST_MV_DIV1:  cmd.op = OP_DIV1;
         ST_MV_WAIT1: cmd.op = status.div_done ? OP_ALIM : OP_NONE;
         ST_MV_MUL2:  cmd.op = OP_MUL2;
         ST_MV_DIV2:  cmd.op = OP_DIV2;
         ST_MV_WAIT2: cmd.op = OP_NONE;
         ST_MV_PLAN:  cmd.op = OP_PLAN;
         ST_TK_WAIT:  cmd.op = OP_NONE;
         ST_TK_FIN:   cmd.op = status.out_free ? OP_TK_FIN : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/stepper_trapezoid_ramp_top.sv
// Top level of the stepper trapezoid ramp generator.
// Depends on str_pkg, str_ctrl and str_datapath.
//
// The request channel carries move beats (func 0, signed step count) and
// tick beats (func 1). A move plans a new ramp and returns nothing. Each
// tick returns one response beat with the delay of the step just issued,
// the position after it, the new phase, the direction and the run flag.
// The user must write the registers through the csr port only while the
// block is idle; the block itself does not enforce this.
//
// A tick in accelerate or decelerate phase runs the recurrence division
// in the serial divider, one bit per cycle, before its response; ticks in
// stop or run skip the division. A move of two or more steps occupies the
// block for one or two passes of the same divider. Moves of zero or one
// step finish in the cycle they are accepted. Synchronous reset restores
// the register defaults, clears the position and puts the ramp in stop. A
// stalled response holds in the output register; the next tick waits only
// if a second response would be due.
module stepper_trapezoid_ramp_top
   import str_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   str_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   str_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: rtl/str_checker.sv
// Port-level checker for the stepper ramp top level, with its bind.
// Depends on str_pkg and the assertion macros header.
`include "stepper_trapezoid_ramp_top_macros.svh"

module str_checker
   import str_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic move_beat;
   logic tick_beat;
   logic rsp_stall;
   logic rsp_idle;

   assign move_beat = req_valid && req_ready && (req_data.func == FUNC_MOVE);
   assign tick_beat = req_valid && req_ready && (req_data.func == FUNC_TICK);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_idle  = rsp_valid && !rsp_data.running_out;

   `STR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `STR_ASSERT_NXT(a_move_no_rsp, clock, reset, move_beat, !$rose(rsp_valid))
   `STR_ASSERT_NXT(a_tick_busy, clock, reset, tick_beat, !req_ready)
   `STR_ASSERT_IMP(a_idle_stop, clock, reset, rsp_idle, rsp_data.phase_out == PH_STOP)

endmodule

bind stepper_trapezoid_ramp_top str_checker u_str_checker (.*);
